@@ rtl/assert_macros.svh @@
// Assertion macros used by the RTL.
// Each takes a label, clock, reset, antecedent, consequent and a message.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_SAME(label, clk, rst, a, b, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) else $error(msg);
`define ASSERT_NEXT(label, clk, rst, a, b, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) else $error(msg);
`else
`define ASSERT_SAME(label, clk, rst, a, b, msg)
`define ASSERT_NEXT(label, clk, rst, a, b, msg)
`endif
`endif

@@ rtl/fkw_pkg.sv @@
// ----------------------------------------------------------------------------
// fkw_pkg
// Types and constants of the wrist forward kinematics pipeline.
// ----------------------------------------------------------------------------
`default_nettype none
package fkw_pkg;

   localparam int TRIG_WIDTH  = 16;
   localparam int X_WIDTH     = 19;
   localparam int Z_WIDTH     = 18;
   localparam int CSR_IDX_W   = 3;
   localparam int SINE_STAGES = 5;
   // prep stage, sine stages, four combine stages
   localparam int PIPE_DEPTH  = 1 + SINE_STAGES + 4;

   typedef logic signed [TRIG_WIDTH-1:0] trig_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BASE_OFFSET = 3'd0,
      CSR_UPPER_ARM   = 3'd1,
      CSR_FOREARM     = 3'd2,
      CSR_HAND        = 3'd3,
      CSR_TOOL        = 3'd4,
      CSR_ROLL_MODE   = 3'd5
   } csr_index_type;

   // sine unit lanes
   localparam int NUM_SINE = 11;
   localparam int SIN_Q0   = 0;
   localparam int COS_Q0   = 1;
   localparam int SIN_Q1   = 2;
   localparam int COS_Q1   = 3;
   localparam int SIN_Q12  = 4;
   localparam int COS_Q12  = 5;
   localparam int SIN_Q123 = 6;
   localparam int COS_Q123 = 7;
   localparam int COS_Q4   = 8;
   localparam int SIN_Q04  = 9;
   localparam int COS_Q04  = 10;

endpackage
`default_nettype wire

@@ rtl/fkw_sine.sv @@
// ----------------------------------------------------------------------------
// fkw_sine
// Five-stage Q1.15 sine of a binary angle, polynomial on the quarter wave.
// ----------------------------------------------------------------------------
`default_nettype none
module fkw_sine #(
   parameter int ANGLE_WIDTH = 16
) (
   input  wire logic                   clock,
   input  wire logic                   en,
   input  wire logic [ANGLE_WIDTH-1:0] angle,
   output fkw_pkg::trig_type           sine
);
   import fkw_pkg::*;

   localparam int FW = ANGLE_WIDTH - 2;
   localparam int PAD = 32 - ANGLE_WIDTH;

   logic [29:0] frac30;
   logic [30:0] mirror;
   logic [15:0] u_in, u_a_ff, u_b_ff, u_c_ff, u_d_ff;
   logic        neg_a_ff, neg_b_ff, neg_c_ff, neg_d_ff;
   logic [15:0] u2_in, u2_b_ff, u2_c_ff;
   logic [31:0] sq;
   logic [31:0] pc;
   logic [15:0] t_in, t_c_ff;
   logic [31:0] pd;
   logic [15:0] t2_in, t2_d_ff;
   logic [31:0] pe;
   logic [16:0] s_raw;
   logic [15:0] s_sat;
   trig_type    sine_in, sine_ff;

   // fold into the first quadrant
   assign frac30 = {angle[FW-1:0], {PAD{1'b0}}};
   assign mirror = 31'h4000_0000 - {1'b0, frac30};
   assign u_in   = angle[ANGLE_WIDTH-2] ? mirror[30:15] : {1'b0, frac30[29:15]};

   assign sq    = {16'd0, u_a_ff} * {16'd0, u_a_ff};
   assign u2_in = sq[30:15];

   assign pc   = {16'd0, u2_b_ff} * 32'd2320;
   assign t_in = pc[30:15];

   assign pd    = (32'd21024 - {16'd0, t_c_ff}) * {16'd0, u2_c_ff};
   assign t2_in = pd[30:15];

   assign pe    = (32'd51472 - {16'd0, t2_d_ff}) * {16'd0, u_d_ff};
   assign s_raw = pe[31:15];
   assign s_sat = (s_raw > 17'd32767) ? 16'd32767 : s_raw[15:0];
   assign sine_in = neg_d_ff ? -$signed(s_sat) : $signed(s_sat);

   always_ff @(posedge clock) begin
      if (en) begin
         u_a_ff   <= u_in;
         neg_a_ff <= angle[ANGLE_WIDTH-1];
         u_b_ff   <= u_a_ff;
         neg_b_ff <= neg_a_ff;
         u2_b_ff  <= u2_in;
         u_c_ff   <= u_b_ff;
         neg_c_ff <= neg_b_ff;
         u2_c_ff  <= u2_b_ff;
         t_c_ff   <= t_in;
         u_d_ff   <= u_c_ff;
         neg_d_ff <= neg_c_ff;
         t2_d_ff  <= t2_in;
         sine_ff  <= sine_in;
      end
   end

   assign sine = sine_ff;
endmodule
`default_nettype wire

@@ rtl/fkw_combine.sv @@
// ----------------------------------------------------------------------------
// fkw_combine
// Four stages: link products, reach sums, rotation products, final round.
// ----------------------------------------------------------------------------
`default_nettype none
module fkw_combine #(
   parameter int LENGTH_WIDTH = 15
) (
   input  wire logic                         clock,
   input  wire logic                         en,
   input  fkw_pkg::trig_type                 trig [fkw_pkg::NUM_SINE],
   input  wire logic [LENGTH_WIDTH-1:0]      len0,
   input  wire logic [LENGTH_WIDTH-1:0]      len1,
   input  wire logic [LENGTH_WIDTH-1:0]      len2,
   input  wire logic [LENGTH_WIDTH-1:0]      len3,
   input  wire logic [LENGTH_WIDTH-1:0]      len4,
   input  wire logic                         roll_mode,
   output logic signed [fkw_pkg::X_WIDTH-1:0] x_pos,
   output logic signed [fkw_pkg::X_WIDTH-1:0] y_pos,
   output logic signed [fkw_pkg::Z_WIDTH-1:0] z_pos
);
   import fkw_pkg::*;

   localparam int PW   = LENGTH_WIDTH + 1 + TRIG_WIDTH;
   localparam int RW   = LENGTH_WIDTH + 19;
   localparam int MW   = RW + TRIG_WIDTH;
   localparam int AWR  = LENGTH_WIDTH + 37;
   localparam int AW   = (AWR > 30 + X_WIDTH) ? AWR : 30 + X_WIDTH;
   localparam logic signed [AW-1:0] HALF = AW'(64'sd1 << 29);

   function automatic logic signed [PW-1:0] lmul(input logic [LENGTH_WIDTH-1:0] l,
                                                 input trig_type t);
      return $signed({1'b0, l}) * t;
   endfunction

   // stage 1
   logic signed [PW-1:0] c1_ff, c12_ff, c123_ff, s1_ff, s12_ff, k4_ff, kx_ff, ky_ff;
   trig_type             cq0_ff, sq0_ff, sq123_ff;
   // stage 2
   logic signed [RW-1:0] r_ff, last_ff, zh_ff;
   logic signed [PW-1:0] kx2_ff, ky2_ff;
   trig_type             cq0b_ff, sq0b_ff, sq123b_ff;
   logic signed [RW-1:0] r_in, last_in, zh_in;
   // stage 3
   logic signed [MW-1:0] xp_ff, yp_ff, zp_ff;
   logic signed [PW-1:0] kx3_ff, ky3_ff;
   logic signed [RW-1:0] zh3_ff;
   // stage 4
   logic signed [AW-1:0] xs_in, ys_in, zs_in;
   logic signed [X_WIDTH-1:0] x_ff, y_ff;
   logic signed [Z_WIDTH-1:0] z_ff;

   assign r_in    = RW'(c1_ff) + RW'(c12_ff) + RW'(c123_ff)
                  + $signed({4'd0, len0, 15'd0});
   assign last_in = $signed({4'd0, len3, 15'd0}) + RW'(k4_ff);
   assign zh_in   = RW'(s1_ff) + RW'(s12_ff);

   assign xs_in = AW'(xp_ff) + (AW'(kx3_ff) <<< 15) + HALF;
   assign ys_in = AW'(yp_ff) + (AW'(ky3_ff) <<< 15) + HALF;
   assign zs_in = AW'(zp_ff) + (AW'(zh3_ff) <<< 15) + HALF;

   always_ff @(posedge clock) begin
      if (en) begin
         c1_ff    <= lmul(len1, trig[COS_Q1]);
         c12_ff   <= lmul(len2, trig[COS_Q12]);
         c123_ff  <= lmul(len3, trig[COS_Q123]);
         s1_ff    <= lmul(len1, trig[SIN_Q1]);
         s12_ff   <= lmul(len2, trig[SIN_Q12]);
         k4_ff    <= roll_mode ? lmul(len4, trig[COS_Q4])  : '0;
         kx_ff    <= roll_mode ? lmul(len4, trig[COS_Q04]) : '0;
         ky_ff    <= roll_mode ? lmul(len4, trig[SIN_Q04]) : '0;
         cq0_ff   <= trig[COS_Q0];
         sq0_ff   <= trig[SIN_Q0];
         sq123_ff <= trig[SIN_Q123];

         r_ff      <= r_in;
         last_ff   <= last_in;
         zh_ff     <= zh_in;
         kx2_ff    <= kx_ff;
         ky2_ff    <= ky_ff;
         cq0b_ff   <= cq0_ff;
         sq0b_ff   <= sq0_ff;
         sq123b_ff <= sq123_ff;

         xp_ff  <= r_ff * cq0b_ff;
         yp_ff  <= r_ff * sq0b_ff;
         zp_ff  <= last_ff * sq123b_ff;
         kx3_ff <= kx2_ff;
         ky3_ff <= ky2_ff;
         zh3_ff <= zh_ff;

         // floor of (v + half) / 2^30, kept to the output width
         x_ff <= xs_in[30 +: X_WIDTH];
         y_ff <= ys_in[30 +: X_WIDTH];
         z_ff <= zs_in[30 +: Z_WIDTH];
      end
   end

   assign x_pos = x_ff;
   assign y_pos = y_ff;
   assign z_pos = z_ff;
endmodule
`default_nettype wire

@@ rtl/arm_forward_kinematics_wrist.sv @@
// ----------------------------------------------------------------------------
// arm_forward_kinematics_wrist
// Wrist-point x, y, z of a five-joint serial arm from binary joint angles.
// ----------------------------------------------------------------------------
//   channel  direction  handshake            beat
//   req_     in         req_valid/req_stall  five joint angles
//   rsp_     out        rsp_valid/rsp_stall  x, y, z of the wrist point
//   csr_     in         csr_valid/csr_ready  register index and write data
//
// One beat enters per cycle while req_stall is low; each result passes through
// one angle-sum stage, five stages of the sine polynomial in each of eleven
// lanes (a quarter-wave fold, then one multiply per later stage), then four
// stages of link products, sums, rotation products and rounding. The pipeline
// advances together and holds when the output register is full and rsp_stall
// is high. Reset clears the valid bits and the CSRs; csr_ready is always high.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module arm_forward_kinematics_wrist #(
   parameter int ANGLE_WIDTH  = 16,
   parameter int LENGTH_WIDTH = 15
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_stall,
   input  wire logic signed [ANGLE_WIDTH-1:0]  req_base_yaw_angle,
   input  wire logic signed [ANGLE_WIDTH-1:0]  req_shoulder_angle,
   input  wire logic signed [ANGLE_WIDTH-1:0]  req_elbow_angle,
   input  wire logic signed [ANGLE_WIDTH-1:0]  req_wrist_pitch_angle,
   input  wire logic signed [ANGLE_WIDTH-1:0]  req_wrist_roll_angle,
   output logic                                rsp_valid,
   input  wire logic                           rsp_stall,
   output logic signed [fkw_pkg::X_WIDTH-1:0]  rsp_x_position,
   output logic signed [fkw_pkg::X_WIDTH-1:0]  rsp_y_position,
   output logic signed [fkw_pkg::Z_WIDTH-1:0]  rsp_z_position,
   input  wire logic                           csr_valid,
   output logic                                csr_ready,
   input  wire logic [fkw_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [LENGTH_WIDTH-1:0]        csr_wdata
);
   import fkw_pkg::*;

   localparam logic [ANGLE_WIDTH-1:0] QUARTER = {2'b01, {(ANGLE_WIDTH-2){1'b0}}};

   // configuration registers
   logic [LENGTH_WIDTH-1:0] len0_ff, len1_ff, len2_ff, len3_ff, len4_ff;
   logic                    roll_mode_ff;

   // pipeline control: valid bits travel with the data
   logic                  en;
   logic [PIPE_DEPTH-1:0] vld_ff, vld_in;

   // angle-sum stage
   logic [ANGLE_WIDTH-1:0] ang_in [NUM_SINE];
   logic [ANGLE_WIDTH-1:0] ang_ff [NUM_SINE];
   logic [ANGLE_WIDTH-1:0] q12, q123, q04;
   trig_type               trig [NUM_SINE];

   // advance whenever the output register is empty or being drained
   assign en        = !vld_ff[PIPE_DEPTH-1] || !rsp_stall;
   assign req_stall = !en;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         len0_ff      <= '0;
         len1_ff      <= '0;
         len2_ff      <= '0;
         len3_ff      <= '0;
         len4_ff      <= '0;
         roll_mode_ff <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index_type'(csr_index))
            CSR_BASE_OFFSET: len0_ff      <= csr_wdata;
            CSR_UPPER_ARM:   len1_ff      <= csr_wdata;
            CSR_FOREARM:     len2_ff      <= csr_wdata;
            CSR_HAND:        len3_ff      <= csr_wdata;
            CSR_TOOL:        len4_ff      <= csr_wdata;
            CSR_ROLL_MODE:   roll_mode_ff <= csr_wdata[0];
            default: ;       // drop writes beyond the register list
         endcase
      end
   end

   // joint sums wrap modulo one turn; cosine is sine a quarter turn on
   assign q12  = req_shoulder_angle + req_elbow_angle;
   assign q123 = q12 + req_wrist_pitch_angle;
   assign q04  = req_base_yaw_angle + req_wrist_roll_angle;

   always_comb begin
      ang_in[SIN_Q0]   = req_base_yaw_angle;
      ang_in[COS_Q0]   = req_base_yaw_angle + QUARTER;
      ang_in[SIN_Q1]   = req_shoulder_angle;
      ang_in[COS_Q1]   = req_shoulder_angle + QUARTER;
      ang_in[SIN_Q12]  = q12;
      ang_in[COS_Q12]  = q12 + QUARTER;
      ang_in[SIN_Q123] = q123;
      ang_in[COS_Q123] = q123 + QUARTER;
      ang_in[COS_Q4]   = req_wrist_roll_angle + QUARTER;
      ang_in[SIN_Q04]  = q04;
      ang_in[COS_Q04]  = q04 + QUARTER;
   end

   assign vld_in = {vld_ff[PIPE_DEPTH-2:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ang_ff <= ang_in;
      end
   end

   // one sine lane per trig term
   for (genvar g = 0; g < NUM_SINE; g++) begin : g_sine
      fkw_sine #(
         .ANGLE_WIDTH(ANGLE_WIDTH)
      ) u_sine (
         .clock(clock),
         .en   (en),
         .angle(ang_ff[g]),
         .sine (trig[g])
      );
   end

   fkw_combine #(
      .LENGTH_WIDTH(LENGTH_WIDTH)
   ) u_combine (
      .clock    (clock),
      .en       (en),
      .trig     (trig),
      .len0     (len0_ff),
      .len1     (len1_ff),
      .len2     (len2_ff),
      .len3     (len3_ff),
      .len4     (len4_ff),
      .roll_mode(roll_mode_ff),
      .x_pos    (rsp_x_position),
      .y_pos    (rsp_y_position),
      .z_pos    (rsp_z_position)
   );

   assign rsp_valid = vld_ff[PIPE_DEPTH-1];

   `ASSERT_NEXT(a_accept_enters, clock, reset, req_valid && !req_stall, vld_ff[0], "accepted beat lost at entry")
   `ASSERT_NEXT(a_hold_on_stall, clock, reset, !en, $stable(vld_ff), "pipeline moved while held")
   `ASSERT_SAME(a_stall_only_full, clock, reset, req_stall, rsp_valid && rsp_stall, "input held without a full output")

endmodule
`default_nettype wire
